// ----- design/efbp_pkg.sv -----
// Shared types, constants and status codes for the fuse bank programmer.
// No dependencies; imported by every design file.
package efbp_pkg;

  // Array geometry
  localparam int NUM_BANKS = 32;
  localparam int LOCK_IDX  = 31;
  localparam int WORD_W    = 32;
  localparam int BANK_W    = 5;
  // Banks that hold data: below the lock bank and below the bank count
  localparam int NUM_DATA  = (LOCK_IDX < NUM_BANKS) ? LOCK_IDX : NUM_BANKS;
  localparam int DATA_AW   = (NUM_DATA > 1) ? $clog2(NUM_DATA) : 1;
  localparam bit LOCK_PRESENT = (LOCK_IDX < NUM_BANKS);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [BANK_W-1:0] bank_t;

  // Request kinds
  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_SET = 1'b1;

  // Result status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_BYPASS   = 2'd1;
  localparam status_t ST_RANGE    = 2'd2;
  localparam status_t ST_LOCKED   = 2'd3;

  // Configuration registers
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_LOW  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_HIGH = 1'd1;
  localparam bank_t WRITE_LOW_RST  = 5'd7;
  localparam bank_t WRITE_HIGH_RST = 5'd11;

endpackage

// ----- design/efuse_bank_program_with_lock.sv -----
// Fuse bank programmer with per-bank lock bitmap.
// A request is captured and its bank word read at accept; S_EVAL decides,
// writes back and registers the result strobe and payload. busy (S_EVAL)
// blocks new requests; the registered fuse read feeds the read-modify-write.
// Reset (rst_n, synchronous) blanks all fuses and the lock bitmap and loads the
// write window to banks 7..11. The receiver cannot stall the result.
module efuse_bank_program_with_lock import efbp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_func,
  input  logic [4:0]           in_bank_index,
  input  logic [31:0]          in_write_value,
  input  logic                 in_lock_request,
  output logic                 out_valid,
  output logic [1:0]           out_status,
  output logic [31:0]          out_read_value,
  output logic                 out_locked_flag,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [4:0]           cfg_wdata
);

  efbp_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_bank_index   (in_bank_index),
    .in_write_value  (in_write_value),
    .in_lock_request (in_lock_request),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_read_value  (out_read_value),
    .out_locked_flag (out_locked_flag),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

endmodule

// ----- design/efbp_fuse_mem.sv -----
// Fuse word store: one-port-write, one-port-read synchronous memory with
// per-entry valid bits so unwritten (blank) entries read as zero.
// Depends on efbp_pkg.
module efbp_fuse_mem import efbp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               rd_en,
  input  logic [DATA_AW-1:0] rd_addr,
  output word_t              rd_data,
  input  logic               wr_en,
  input  logic [DATA_AW-1:0] wr_addr,
  input  word_t              wr_data
);

  word_t               mem [NUM_DATA];
  logic [NUM_DATA-1:0] valid_r;
  word_t               rd_data_r;
  logic                rd_valid_r;

  // Storage array and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Valid bits: cleared at reset, blank fuses read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_data_r : '0;

endmodule

// ----- design/efbp_ctrl.sv -----
// Request sequencer: captures a transaction, reads the bank word, decides,
// writes back and presents the result. Holds the lock bitmap and window.
// Depends on efbp_pkg and efbp_fuse_mem.
module efbp_ctrl import efbp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_func,
  input  bank_t                in_bank_index,
  input  word_t                in_write_value,
  input  logic                 in_lock_request,
  output logic                 out_valid,
  output status_t              out_status,
  output word_t                out_read_value,
  output logic                 out_locked_flag,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  bank_t                cfg_wdata
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EVAL = 1'b1;

  logic                state_r, state_nxt;
  logic                func_r;
  bank_t               bank_r;
  word_t               value_r;
  logic                lock_req_r;
  bank_t               low_r, high_r;
  logic [NUM_DATA-1:0] lock_r;

  logic                accept;
  logic                in_range_in;
  word_t               cur_word;
  logic                addressable;
  logic                bank_locked;
  logic                in_window;
  logic                go;
  logic                do_write;
  status_t             status_nxt;
  word_t               rd_nxt;
  logic                lk_nxt;
  logic [DATA_AW-1:0]  bank_addr;

  assign accept      = start && !busy;
  assign busy        = (state_r == S_EVAL);
  assign in_range_in = ({1'b0, in_bank_index} < (BANK_W+1)'(NUM_DATA));
  assign bank_addr   = DATA_AW'(bank_r);

  efbp_fuse_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept && in_range_in),
    .rd_addr (DATA_AW'(in_bank_index)),
    .rd_data (cur_word),
    .wr_en   (do_write),
    .wr_addr (bank_addr),
    .wr_data (cur_word | value_r)
  );

  // Decision on the word read back
  always_comb begin
    addressable = ({1'b0, bank_r} < (BANK_W+1)'(NUM_DATA));
    bank_locked = addressable ? lock_r[bank_addr] : 1'b0;
    in_window   = (bank_r >= low_r) && (bank_r <= high_r);
    go          = (((cur_word & value_r) == '0) && (value_r != '0)) ||
                  ((value_r == '0) && lock_req_r);
    status_nxt  = ST_OK;
    rd_nxt      = '0;
    lk_nxt      = 1'b0;
    do_write    = 1'b0;
    if (!addressable) begin
      status_nxt = ST_RANGE;
    end else if (func_r == FUNC_GET) begin
      rd_nxt = cur_word;
      lk_nxt = bank_locked;
    end else if (!in_window) begin
      status_nxt = ST_RANGE;
    end else if (bank_locked) begin
      status_nxt = ST_LOCKED;
    end else if (go) begin
      do_write = (state_r == S_EVAL);
    end else begin
      status_nxt = ST_BYPASS;
    end
  end

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_EVAL;
      end
      S_EVAL: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state, window, lock bitmap, result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
      low_r     <= WRITE_LOW_RST;
      high_r    <= WRITE_HIGH_RST;
      lock_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= (state_r == S_EVAL);
      if (cfg_we) begin
        case (cfg_index)
          CFG_WRITE_LOW:  low_r  <= cfg_wdata;
          CFG_WRITE_HIGH: high_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (do_write && lock_req_r && LOCK_PRESENT) begin
        lock_r[bank_addr] <= 1'b1;
      end
    end
  end

  // Transaction capture and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r     <= in_func;
      bank_r     <= in_bank_index;
      value_r    <= in_write_value;
      lock_req_r <= in_lock_request;
    end
    if (state_r == S_EVAL) begin
      out_status      <= status_nxt;
      out_read_value  <= rd_nxt;
      out_locked_flag <= lk_nxt;
    end
  end

endmodule
